### rtl/pwm_pkg.sv
// ----------------------------------------------------------------------------
// pwm_pkg
// Shared constants, codes and control/status types of the phase wave node.
// ----------------------------------------------------------------------------
package pwm_pkg;

    localparam int MAX_IN         = 4;
    localparam int MAX_OUT        = 4;
    localparam int ID_BITS        = 8;
    localparam int PHASE_W        = 4;
    localparam int VALUE_W        = 32;
    localparam int CFG_W          = 32;
    localparam int CFG_IDX_W      = 3;
    localparam int CNT_REG_W      = 3;
    localparam int PHASE_MAX      = 15;
    localparam int DIAMETER_RESET = 5;

    localparam int SLOT_W    = (MAX_OUT > 1) ? $clog2(MAX_OUT) : 1;
    localparam int OUT_CNT_W = $clog2(MAX_OUT + 1);

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_IN_COUNT    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IN_IDS      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_COUNT   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_IDS     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DIAMETER    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_LOCAL_VALUE = 3'd5;

    // input op codes
    localparam logic OP_START = 1'b0;
    localparam logic OP_MSG   = 1'b1;

    // result kinds
    localparam logic KIND_SEND = 1'b0;
    localparam logic KIND_FIN  = 1'b1;

    typedef struct packed {
        logic              take;       // input word accepted this cycle
        logic              load_out;   // load the result register
        logic              out_fin;    // loaded result is the finish word
        logic [SLOT_W-1:0] out_slot;   // out-neighbor slot of a send word
        logic              out_last;   // loaded result ends the burst
        logic              inc_phase;  // advance own phase
    } t_cmd;

    typedef struct packed {
        logic                 live;       // started and not finished
        logic                 done_now;
        logic                 may_now;
        logic                 done_next;  // same checks at own phase + 1
        logic                 may_next;
        logic [OUT_CNT_W-1:0] n_out;      // out-neighbors in use, clamped
    } t_status;

    // id of one slot in a packed id register; slots past the word read as zero
    function automatic logic [ID_BITS-1:0] slot_id(input logic [CFG_W-1:0] packed_ids,
                                                   input int slot);
        logic [CFG_W-1:0] shifted;
        shifted = '0;
        if (slot * ID_BITS >= CFG_W) begin
            return '0;
        end
        shifted = packed_ids >> (slot * ID_BITS);
        return shifted[ID_BITS-1:0];
    endfunction

endpackage

### rtl/pwm_in_if.sv
// ----------------------------------------------------------------------------
// pwm_in_if
// Input channel of the phase wave node: start and message words.
// ----------------------------------------------------------------------------
interface pwm_in_if;
    import pwm_pkg::*;

    logic                      valid;
    logic                      ready;
    logic                      op;
    logic [ID_BITS-1:0]        sender;
    logic signed [VALUE_W-1:0] value;

    modport source (output valid, output op, output sender, output value, input ready);
    modport sink   (input valid, input op, input sender, input value, output ready);
endinterface

### rtl/pwm_out_if.sv
// ----------------------------------------------------------------------------
// pwm_out_if
// Result channel of the phase wave node: send and finish words.
// ----------------------------------------------------------------------------
interface pwm_out_if;
    import pwm_pkg::*;

    logic                      valid;
    logic                      ready;
    logic                      kind;
    logic [ID_BITS-1:0]        dest;
    logic signed [VALUE_W-1:0] current_min;
    logic                      last;

    modport source (output valid, output kind, output dest, output current_min,
                    output last, input ready);
    modport sink   (input valid, input kind, input dest, input current_min,
                    input last, output ready);
endinterface

### rtl/pwm_datapath.sv
// ----------------------------------------------------------------------------
// pwm_datapath
// Configuration registers, running minimum, phase counters, phase checks
// and the result register of the phase wave node.
// ----------------------------------------------------------------------------
module pwm_datapath (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [pwm_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [pwm_pkg::CFG_W-1:0]          i_cfg_data,
    input  logic                               i_op,
    input  logic [pwm_pkg::ID_BITS-1:0]        i_sender,
    input  logic signed [pwm_pkg::VALUE_W-1:0] i_value,
    input  pwm_pkg::t_cmd                      i_cmd,
    output pwm_pkg::t_status                   o_status,
    output logic                               o_kind,
    output logic [pwm_pkg::ID_BITS-1:0]        o_dest,
    output logic signed [pwm_pkg::VALUE_W-1:0] o_current_min,
    output logic                               o_last
);
    import pwm_pkg::*;

    logic [CNT_REG_W-1:0]      r_in_count;
    logic [CFG_W-1:0]          r_in_ids;
    logic [CNT_REG_W-1:0]      r_out_count;
    logic [CFG_W-1:0]          r_out_ids;
    logic [PHASE_W-1:0]        r_diameter;
    logic signed [VALUE_W-1:0] r_local_value;

    logic signed [VALUE_W-1:0] r_min;
    logic [PHASE_W-1:0]        r_own;
    logic [PHASE_W-1:0]        r_nb [MAX_IN];
    logic                      r_started;
    logic                      r_finished;

    logic                      r_kind;
    logic [ID_BITS-1:0]        r_dest;
    logic signed [VALUE_W-1:0] r_cur_min;
    logic                      r_last;

    logic [MAX_IN-1:0]         in_active;
    logic [MAX_IN-1:0]         hit;
    logic [MAX_IN-1:0]         first_hit;
    logic [PHASE_W-1:0]        own_next;
    logic [ID_BITS-1:0]        dest_sel;

    always_comb begin
        logic seen;
        seen = 1'b0;
        for (int i = 0; i < MAX_IN; i++) begin
            in_active[i] = (i < int'(r_in_count));
            hit[i]       = in_active[i] && (slot_id(r_in_ids, i) == i_sender);
            first_hit[i] = hit[i] && !seen;
            seen         = seen | hit[i];
        end
    end

    assign own_next = r_own + PHASE_W'(1);

    always_comb begin
        o_status.live      = r_started && !r_finished;
        o_status.done_now  = (r_own >= r_diameter);
        o_status.may_now   = (int'(r_own) < PHASE_MAX);
        o_status.done_next = (own_next >= r_diameter);
        o_status.may_next  = (int'(own_next) < PHASE_MAX);
        for (int i = 0; i < MAX_IN; i++) begin
            if (in_active[i]) begin
                if (r_nb[i] < r_diameter) begin
                    o_status.done_now  = 1'b0;
                    o_status.done_next = 1'b0;
                end
                if (r_own > r_nb[i]) begin
                    o_status.may_now = 1'b0;
                end
                if (own_next > r_nb[i]) begin
                    o_status.may_next = 1'b0;
                end
            end
        end
        if (int'(r_out_count) > MAX_OUT) begin
            o_status.n_out = OUT_CNT_W'(MAX_OUT);
        end else begin
            o_status.n_out = OUT_CNT_W'(r_out_count);
        end
    end

    always_comb begin
        dest_sel = '0;
        for (int i = 0; i < MAX_OUT; i++) begin
            if (i_cmd.out_slot == SLOT_W'(i)) begin
                dest_sel = slot_id(r_out_ids, i);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_count    <= '0;
            r_in_ids      <= '0;
            r_out_count   <= '0;
            r_out_ids     <= '0;
            r_diameter    <= PHASE_W'(DIAMETER_RESET);
            r_local_value <= '0;
            r_min         <= '0;
            r_own         <= '0;
            r_started     <= 1'b0;
            r_finished    <= 1'b0;
            for (int i = 0; i < MAX_IN; i++) begin
                r_nb[i] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_IN_COUNT:    r_in_count    <= i_cfg_data[CNT_REG_W-1:0];
                    CFG_IN_IDS:      r_in_ids      <= i_cfg_data;
                    CFG_OUT_COUNT:   r_out_count   <= i_cfg_data[CNT_REG_W-1:0];
                    CFG_OUT_IDS:     r_out_ids     <= i_cfg_data;
                    CFG_DIAMETER:    r_diameter    <= i_cfg_data[PHASE_W-1:0];
                    CFG_LOCAL_VALUE: r_local_value <= $signed(i_cfg_data[VALUE_W-1:0]);
                    default: ;
                endcase
            end
            if (i_cmd.take) begin
                if (i_op == OP_START) begin
                    r_min      <= r_local_value;
                    r_own      <= '0;
                    r_started  <= 1'b1;
                    r_finished <= 1'b0;
                    for (int i = 0; i < MAX_IN; i++) begin
                        r_nb[i] <= '0;
                    end
                end else if (o_status.live) begin
                    if (i_value < r_min) begin
                        r_min <= i_value;
                    end
                    for (int i = 0; i < MAX_IN; i++) begin
                        if (first_hit[i] && int'(r_nb[i]) < PHASE_MAX) begin
                            r_nb[i] <= r_nb[i] + PHASE_W'(1);
                        end
                    end
                end
            end
            if (i_cmd.inc_phase) begin
                r_own <= own_next;
            end
            if (i_cmd.load_out && i_cmd.out_fin) begin
                r_finished <= 1'b1;
            end
        end
    end

    // result word: payload only, valid lives in the controller
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_kind    <= i_cmd.out_fin ? KIND_FIN : KIND_SEND;
            r_dest    <= i_cmd.out_fin ? '0 : dest_sel;
            r_cur_min <= r_min;
            r_last    <= i_cmd.out_last;
        end
    end

    assign o_kind        = r_kind;
    assign o_dest        = r_dest;
    assign o_current_min = r_cur_min;
    assign o_last        = r_last;

endmodule

### rtl/pwm_ctrl.sv
// ----------------------------------------------------------------------------
// pwm_ctrl
// Sequencer of the phase wave node: takes one input word, then runs the
// phase rounds and steps through the result words of each round.
// ----------------------------------------------------------------------------
module pwm_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_in_op,
    output logic             o_in_ready,
    input  logic             i_out_ready,
    output logic             o_out_valid,
    input  pwm_pkg::t_status i_status,
    output pwm_pkg::t_cmd    o_cmd
);
    import pwm_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EVAL,
        S_SEND,
        S_FIN
    } t_state;

    t_state            r_state, n_state;
    logic [SLOT_W-1:0] r_slot, n_slot;
    logic              r_out_valid, n_out_valid;
    logic              more_next;
    logic              slot_is_last;
    logic              next_is_last;

    // a following round would emit something, so this round's last send is not final
    assign more_next    = i_status.done_next || i_status.may_next;
    assign slot_is_last = (OUT_CNT_W'(r_slot) + OUT_CNT_W'(1)) == i_status.n_out;
    assign next_is_last = (OUT_CNT_W'(r_slot) + OUT_CNT_W'(2)) == i_status.n_out;

    always_comb begin
        n_state     = r_state;
        n_slot      = r_slot;
        n_out_valid = r_out_valid;
        o_cmd       = '0;
        o_in_ready  = (r_state == S_IDLE);
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.take = 1'b1;
                    // drop a message while not running
                    if (i_in_op == OP_START || i_status.live) begin
                        n_state = S_EVAL;
                    end
                end
            end
            S_EVAL: begin
                if (i_status.done_now) begin
                    o_cmd.load_out = 1'b1;
                    o_cmd.out_fin  = 1'b1;
                    o_cmd.out_last = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_FIN;
                end else if (i_status.may_now) begin
                    if (i_status.n_out == '0) begin
                        o_cmd.inc_phase = 1'b1;
                    end else begin
                        o_cmd.load_out = 1'b1;
                        o_cmd.out_slot = '0;
                        o_cmd.out_last = (i_status.n_out == OUT_CNT_W'(1)) && !more_next;
                        n_slot         = '0;
                        n_out_valid    = 1'b1;
                        n_state        = S_SEND;
                    end
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_SEND: begin
                if (i_out_ready) begin
                    if (slot_is_last) begin
                        o_cmd.inc_phase = 1'b1;
                        n_out_valid     = 1'b0;
                        n_state         = S_EVAL;
                    end else begin
                        o_cmd.load_out = 1'b1;
                        o_cmd.out_slot = r_slot + SLOT_W'(1);
                        o_cmd.out_last = next_is_last && !more_next;
                        n_slot         = r_slot + SLOT_W'(1);
                    end
                end
            end
            S_FIN: begin
                if (i_out_ready) begin
                    n_out_valid = 1'b0;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state     = S_IDLE;
                n_out_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_slot      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_slot      <= n_slot;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

`ifndef SYNTH
    a_valid_in_out_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_state == S_SEND || r_state == S_FIN))
        else $error("result valid outside an output state");

    a_take_no_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.take |-> !r_out_valid)
        else $error("input taken while a result word is pending");

    a_phase_only_when_allowed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.inc_phase && r_state == S_EVAL) |-> i_status.may_now)
        else $error("phase advanced while a neighbor lags");

    a_finish_only_when_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.load_out && o_cmd.out_fin) |-> (i_status.done_now && o_cmd.out_last))
        else $error("finish word loaded before all phases are done");
`endif

endmodule

### rtl/phase_wave_min_node.sv
// ----------------------------------------------------------------------------
// phase_wave_min_node
// One node of the phase wave algorithm that computes a network-wide minimum.
// ----------------------------------------------------------------------------
// A start word loads local_value as the minimum and clears all phase counts; a
// message word lowers the minimum and bumps the matching in-neighbor's count.
// The node takes one input word at a time. The sequencer takes it while
// idle, then checks the phases; for each round it loads the result words one
// by one as the sink accepts them and then advances the phase, a round with
// no out-neighbors only advancing the phase. The finishing check loads the
// finish word, a check that allows no round returns to idle, and a dropped
// message leaves the sequencer idle. Input ready is high only while the
// sequencer is idle, i.e. after the burst caused by the previous word has
// been fully taken. Messages before start or after finish are dropped. Config
// registers: 0 in_count, 1 in_ids, 2 out_count, 3 out_ids, 4 diameter,
// 5 local_value; write them only while idle.
// ----------------------------------------------------------------------------
module phase_wave_min_node (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [pwm_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [pwm_pkg::CFG_W-1:0]     i_cfg_data,
    pwm_in_if.sink                        i_msg,
    pwm_out_if.source                     o_res
);
    import pwm_pkg::*;

    t_cmd    cmd;
    t_status status;

    pwm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_msg.valid),
        .i_in_op     (i_msg.op),
        .o_in_ready  (i_msg.ready),
        .i_out_ready (o_res.ready),
        .o_out_valid (o_res.valid),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    pwm_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_op          (i_msg.op),
        .i_sender      (i_msg.sender),
        .i_value       (i_msg.value),
        .i_cmd         (cmd),
        .o_status      (status),
        .o_kind        (o_res.kind),
        .o_dest        (o_res.dest),
        .o_current_min (o_res.current_min),
        .o_last        (o_res.last)
    );

endmodule

### bench/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for phase_wave_min_node. A short table of directed
// config writes, start and message words comes first, then random
// start/message runs under changing neighbor setups. Every result word is
// checked against an in-bench model of the node or against its table row.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import pwm_pkg::*;

    localparam int ITEMS_GOAL    = 250;
    localparam int STALL_LIMIT   = 1000;
    localparam int SETTLE_CYCLES = 4;

    typedef struct {
        logic                      kind;
        logic [ID_BITS-1:0]        dest;
        logic signed [VALUE_W-1:0] min_val;
        logic                      last;
    } t_node_word;

    typedef enum logic [1:0] {ROW_CFG, ROW_WORD, ROW_TYPED} t_row_kind;

    // ROW_TYPED rows carry their own expectation: at most one final word
    typedef struct {
        t_row_kind            kind;
        logic [CFG_IDX_W-1:0] idx;
        logic                 op;
        logic [ID_BITS-1:0]   sender;
        logic [CFG_W-1:0]     data;
        bit                   has_res;
        logic                 t_kind;
        logic [ID_BITS-1:0]   t_dest;
        logic [VALUE_W-1:0]   t_min;
    } t_dir_row;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [CFG_W-1:0]     cfg_data;

    pwm_in_if  msg_if();
    pwm_out_if res_if();

    phase_wave_min_node uut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_msg      (msg_if.sink),
        .o_res      (res_if.source)
    );

    // register copies
    logic [CNT_REG_W-1:0]      cf_in_count  = '0;
    logic [CFG_W-1:0]          cf_in_ids    = '0;
    logic [CNT_REG_W-1:0]      cf_out_count = '0;
    logic [CFG_W-1:0]          cf_out_ids   = '0;
    logic [PHASE_W-1:0]        cf_diameter  = PHASE_W'(DIAMETER_RESET);
    logic signed [VALUE_W-1:0] cf_local     = '0;

    // node state copy
    logic signed [VALUE_W-1:0] nd_min = '0;
    logic [PHASE_W-1:0]        nd_phase = '0;
    logic [PHASE_W-1:0]        nd_nbr_phase [MAX_IN] = '{default: '0};
    bit                        nd_started  = 1'b0;
    bit                        nd_finished = 1'b0;

    t_node_word due_words[$];
    t_node_word burst_words[$];

    int mismatches   = 0;
    int quiet_cycles = 0;
    int random_items = 0;
    int tx_idle_pct  = 22;
    int rx_idle_pct  = 57;

    t_dir_row dir_rows [27] = '{
        '{ROW_TYPED, '0, OP_MSG,   8'h00, 32'h0000_0000, 1'b0, '0, '0, '0},
        '{ROW_TYPED, '0, OP_START, 8'h00, 32'h0000_0000, 1'b1, KIND_FIN, 8'h00, 32'h0},
        '{ROW_TYPED, '0, OP_MSG,   8'hFF, 32'h8000_0000, 1'b0, '0, '0, '0},
        '{ROW_CFG, CFG_LOCAL_VALUE, '0, '0, 32'h7FFF_FFFF, 1'b0, '0, '0, '0},
        '{ROW_CFG, CFG_DIAMETER,    '0, '0, 32'h0000_0000, 1'b0, '0, '0, '0},
        '{ROW_TYPED, '0, OP_START, 8'hFF, 32'hFFFF_FFFF, 1'b1, KIND_FIN, 8'h00,
          32'h7FFF_FFFF},
        '{ROW_TYPED, '0, OP_MSG,   8'h00, 32'hFFFF_FFFF, 1'b0, '0, '0, '0},
        '{ROW_CFG, CFG_DIAMETER,    '0, '0, 32'h0000_000F, 1'b0, '0, '0, '0},
        '{ROW_CFG, CFG_IN_COUNT,    '0, '0, 32'h0000_0007, 1'b0, '0, '0, '0},
        '{ROW_CFG, CFG_IN_IDS,      '0, '0, 32'h0303_02FF, 1'b0, '0, '0, '0},
        '{ROW_CFG, CFG_OUT_COUNT,   '0, '0, 32'h0000_0007, 1'b0, '0, '0, '0},
        '{ROW_CFG, CFG_OUT_IDS,     '0, '0, 32'hFF00_A501, 1'b0, '0, '0, '0},
        '{ROW_WORD, '0, OP_START, 8'h00, 32'h0000_0000, 1'b0, '0, '0, '0},
        '{ROW_WORD, '0, OP_MSG,   8'hFF, 32'h8000_0000, 1'b0, '0, '0, '0},
        '{ROW_WORD, '0, OP_MSG,   8'h02, 32'h0000_0000, 1'b0, '0, '0, '0},
        '{ROW_WORD, '0, OP_MSG,   8'h03, 32'h7FFF_FFFF, 1'b0, '0, '0, '0},
        '{ROW_WORD, '0, OP_MSG,   8'h77, 32'hFFFF_FFFF, 1'b0, '0, '0, '0},
        '{ROW_WORD, '0, OP_START, 8'h00, 32'h0000_0000, 1'b0, '0, '0, '0},
        '{ROW_CFG, CFG_IN_COUNT,    '0, '0, 32'h0000_0001, 1'b0, '0, '0, '0},
        '{ROW_CFG, CFG_IN_IDS,      '0, '0, 32'h0000_00AA, 1'b0, '0, '0, '0},
        '{ROW_CFG, CFG_OUT_COUNT,   '0, '0, 32'h0000_0001, 1'b0, '0, '0, '0},
        '{ROW_CFG, CFG_OUT_IDS,     '0, '0, 32'h0000_0055, 1'b0, '0, '0, '0},
        '{ROW_CFG, CFG_LOCAL_VALUE, '0, '0, 32'h8000_0000, 1'b0, '0, '0, '0},
        '{ROW_WORD, '0, OP_START, 8'h00, 32'h0000_0000, 1'b0, '0, '0, '0},
        '{ROW_WORD, '0, OP_MSG,   8'hAA, 32'h7FFF_FFFF, 1'b0, '0, '0, '0},
        '{ROW_WORD, '0, OP_MSG,   8'hBB, 32'h1234_5678, 1'b0, '0, '0, '0},
        '{ROW_WORD, '0, OP_MSG,   8'hAA, 32'h0000_0001, 1'b0, '0, '0, '0}
    };

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial begin
        res_if.ready = 1'b0;
        forever begin
            @(negedge clk);
            res_if.ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    task automatic flag_mismatch(input string what, input logic [VALUE_W-1:0] got,
                                 input logic [VALUE_W-1:0] want);
        mismatches++;
        $display("%0t: %s got %h, want %h", $time, what, got, want);
    endtask

    // Update the node copy for one accepted word and list the words it causes.
    function automatic void predict_burst(input logic op, input logic [ID_BITS-1:0] sender,
                                          input logic signed [VALUE_W-1:0] value);
        int unsigned n_in;
        int unsigned n_out;
        bit          all_done;
        bit          may_send;
        bit          hit;
        t_node_word  w;
        n_in  = (cf_in_count > MAX_IN) ? MAX_IN : cf_in_count;
        n_out = (cf_out_count > MAX_OUT) ? MAX_OUT : cf_out_count;
        burst_words.delete();
        if (op == OP_START) begin
            nd_min      = cf_local;
            nd_phase    = '0;
            nd_started  = 1'b1;
            nd_finished = 1'b0;
            foreach (nd_nbr_phase[i]) nd_nbr_phase[i] = '0;
        end else begin
            if (!nd_started || nd_finished) return;
            if (value < nd_min) nd_min = value;
            // duplicate ids: only the lowest slot moves
            hit = 1'b0;
            for (int i = 0; i < n_in; i++) begin
                if (!hit && cf_in_ids[i*ID_BITS +: ID_BITS] == sender) begin
                    hit = 1'b1;
                    if (nd_nbr_phase[i] != PHASE_MAX) nd_nbr_phase[i]++;
                end
            end
        end
        forever begin
            all_done = (nd_phase >= cf_diameter);
            may_send = (nd_phase != PHASE_MAX);
            for (int i = 0; i < n_in; i++) begin
                if (nd_nbr_phase[i] < cf_diameter) all_done = 1'b0;
                if (nd_phase > nd_nbr_phase[i]) may_send = 1'b0;
            end
            if (all_done) begin
                nd_finished = 1'b1;
                w = '{KIND_FIN, '0, nd_min, 1'b0};
                burst_words.push_back(w);
                break;
            end
            if (!may_send) break;
            for (int i = 0; i < n_out; i++) begin
                w = '{KIND_SEND, cf_out_ids[i*ID_BITS +: ID_BITS], nd_min, 1'b0};
                burst_words.push_back(w);
            end
            nd_phase++;
        end
        if (burst_words.size() > 0) burst_words[$].last = 1'b1;
    endfunction

    task automatic send_word(input logic op, input logic [ID_BITS-1:0] sender,
                             input logic [VALUE_W-1:0] value, input bit keep);
        @(negedge clk);
        if (random_items < ITEMS_GOAL / 3) begin
            tx_idle_pct = 22;
            rx_idle_pct = 57;
        end else if (random_items < 2 * ITEMS_GOAL / 3) begin
            tx_idle_pct = 57;
            rx_idle_pct = 22;
        end else begin
            tx_idle_pct = 0;
            rx_idle_pct = 0;
        end
        while ($urandom_range(99) < tx_idle_pct) begin
            msg_if.valid <= 1'b0;
            @(negedge clk);
        end
        msg_if.valid  <= 1'b1;
        msg_if.op     <= op;
        msg_if.sender <= sender;
        msg_if.value  <= value;
        @(posedge clk);
        while (!msg_if.ready) @(posedge clk);
        predict_burst(op, sender, value);
        if (keep) begin
            foreach (burst_words[k]) due_words.push_back(burst_words[k]);
        end
    endtask

    // drop valid, drain all due words, then let the sequencer go idle
    task automatic settle();
        @(negedge clk);
        msg_if.valid <= 1'b0;
        while (due_words.size() != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_IN_COUNT:    cf_in_count  = data[CNT_REG_W-1:0];
            CFG_IN_IDS:      cf_in_ids    = data;
            CFG_OUT_COUNT:   cf_out_count = data[CNT_REG_W-1:0];
            CFG_OUT_IDS:     cf_out_ids   = data;
            CFG_DIAMETER:    cf_diameter  = data[PHASE_W-1:0];
            CFG_LOCAL_VALUE: cf_local     = data;
            default: ;
        endcase
    endtask

    function automatic logic [VALUE_W-1:0] pick_value();
        case ($urandom_range(9))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    always @(posedge clk) begin : check_word
        t_node_word want;
        if (rst_n && res_if.valid && res_if.ready) begin
            if (due_words.size() == 0) begin
                flag_mismatch("word with nothing due, min", res_if.current_min, '0);
            end else begin
                want = due_words.pop_front();
                if (res_if.kind !== want.kind) begin
                    flag_mismatch("kind", VALUE_W'(res_if.kind), VALUE_W'(want.kind));
                end
                if (res_if.dest !== want.dest) begin
                    flag_mismatch("dest", VALUE_W'(res_if.dest), VALUE_W'(want.dest));
                end
                if (res_if.current_min !== want.min_val) begin
                    flag_mismatch("current_min", res_if.current_min, want.min_val);
                end
                if (res_if.last !== want.last) begin
                    flag_mismatch("last", VALUE_W'(res_if.last), VALUE_W'(want.last));
                end
            end
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (msg_if.valid && msg_if.ready) || (res_if.valid && res_if.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : stimulus
        t_dir_row           row;
        logic [CFG_W-1:0]   ids;
        logic [PHASE_W-1:0] diam;
        logic               op;
        logic [ID_BITS-1:0] sender;
        int unsigned        n_in;
        int unsigned        slot;
        int unsigned        lag;
        int unsigned        len;
        int unsigned        after_fin;
        bit                 flood;
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_idx       = '0;
        cfg_data      = '0;
        msg_if.valid  = 1'b0;
        msg_if.op     = OP_START;
        msg_if.sender = '0;
        msg_if.value  = '0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (dir_rows[r]) begin
            row = dir_rows[r];
            case (row.kind)
                ROW_CFG: begin
                    if (r == 0 || dir_rows[r-1].kind != ROW_CFG) settle();
                    cfg_write(row.idx, row.data);
                end
                ROW_TYPED: begin
                    send_word(row.op, row.sender, row.data, 1'b0);
                    if (row.has_res) begin
                        due_words.push_back(t_node_word'{row.t_kind, row.t_dest,
                                                         row.t_min, 1'b1});
                    end
                end
                default: send_word(row.op, row.sender, row.data, 1'b1);
            endcase
        end

        while (random_items < ITEMS_GOAL) begin
            settle();
            ids = $urandom;
            if ($urandom_range(5) == 0) ids[31:24] = ids[23:16];
            case ($urandom_range(9))
                0: diam = '0;
                1: diam = PHASE_W'(PHASE_MAX);
                default: diam = PHASE_W'($urandom_range(1, 6));
            endcase
            cfg_write(CFG_IN_COUNT, $urandom_range(7));
            cfg_write(CFG_IN_IDS, ids);
            cfg_write(CFG_OUT_COUNT, $urandom_range(7));
            cfg_write(CFG_OUT_IDS, $urandom);
            cfg_write(CFG_DIAMETER, CFG_W'(diam));
            cfg_write(CFG_LOCAL_VALUE, pick_value());

            n_in      = (cf_in_count > MAX_IN) ? MAX_IN : cf_in_count;
            flood     = ($urandom_range(4) == 0);
            len       = $urandom_range(10, 60);
            after_fin = 0;
            send_word(OP_START, ID_BITS'($urandom), pick_value(), 1'b1);
            random_items++;
            for (int step = 0; step < len && after_fin < 2 && random_items < ITEMS_GOAL;
                 step++) begin
                if ($urandom_range(29) == 0) settle();
                op = ($urandom_range(19) == 0) ? OP_START : OP_MSG;
                // favor the slowest neighbor so that runs get to finish
                lag = 0;
                for (int s = 1; s < n_in; s++) begin
                    if (nd_nbr_phase[s] < nd_nbr_phase[lag]) lag = s;
                end
                if (n_in == 0 || $urandom_range(9) == 0) begin
                    sender = ID_BITS'($urandom);
                end else begin
                    if (flood && $urandom_range(3) != 0) slot = 0;
                    else if ($urandom_range(1) == 0) slot = lag;
                    else slot = $urandom_range(n_in - 1);
                    sender = cf_in_ids[slot*ID_BITS +: ID_BITS];
                end
                if (op == OP_START || (nd_started && !nd_finished)) random_items++;
                send_word(op, sender, pick_value(), 1'b1);
                if (nd_finished) after_fin++;
            end
        end

        settle();
        repeat (16) @(negedge clk);
        if (mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

### filelist.f
rtl/pwm_pkg.sv
rtl/pwm_in_if.sv
rtl/pwm_out_if.sv
rtl/pwm_datapath.sv
rtl/pwm_ctrl.sv
rtl/phase_wave_min_node.sv
bench/tb.sv
